>>> src/assert_macros.svh
// Assertion macros used by the transposed matrix multiply core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> src/tmm_pkg.sv
// Package with types and codes of the transposed matrix multiply core.
package tmm_pkg;

  localparam int DATA_W = 32;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

endpackage

>>> src/tmm_store.sv
// Operand store: one write port and one registered read port.
module tmm_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [tmm_pkg::DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [tmm_pkg::DATA_W-1:0] rdata
);

  logic [tmm_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/tmm_mac.sv
// Shared multiply-accumulate unit: registered product, wrapping 32-bit accumulator.
module tmm_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  tmm_pkg::mac_ctrl_t         ctrl,
  input  logic [tmm_pkg::DATA_W-1:0] a,
  input  logic [tmm_pkg::DATA_W-1:0] b,
  output logic [tmm_pkg::DATA_W-1:0] acc,
  output logic                       prod_vld
);

  logic [2*tmm_pkg::DATA_W-1:0] full;
  logic [tmm_pkg::DATA_W-1:0]   prod;

  assign full = a * b;

  always_ff @(posedge clk) begin
    prod <= full[tmm_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + prod;
    end
  end

endmodule

>>> src/transposed_matrix_multiply_core.sv
// Transposed matrix multiply core: product[i][j] = sum over k of At[k][i] * B[k][j].
// Loads can follow back to back while the core is idle.
// A query stalls all commands until its result is registered, so queries run one at a time,
// set by the single multiply-accumulate unit fed from one read port per operand store.
// Synchronous reset sets dim to 64 and idles the sequencer; store contents stay unknown.
module transposed_matrix_multiply_core #(
  parameter int MAX_DIM = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [1:0]         cmd,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic signed [31:0] value,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] product,
  output logic [5:0]         out_row,
  output logic [5:0]         out_col,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         dim
);

  `include "assert_macros.svh"

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = ($clog2(MAX_DIM + 1) > 7) ? $clog2(MAX_DIM + 1) : 7;

  tmm_pkg::state_t    state, state_next;
  tmm_pkg::mac_ctrl_t mac_ctrl;

  logic [6:0]                 dim_q;
  logic [CNT_W-1:0]           k;
  logic [CNT_W-1:0]           n_q;
  logic [CNT_W-1:0]           n_eff;
  logic [5:0]                 qi;
  logic [5:0]                 qj;
  logic                       a_ok;
  logic                       b_ok;
  logic                       rd_vld;
  logic                       issue;
  logic                       cmd_take;
  logic                       is_query;
  logic                       load_ok;
  logic                       a_we;
  logic                       b_we;
  logic                       res_free;
  logic                       pipe_empty;
  logic                       finish;
  logic                       prod_vld;
  logic [ADDR_W-1:0]          waddr;
  logic [ADDR_W-1:0]          a_raddr;
  logic [ADDR_W-1:0]          b_raddr;
  logic [tmm_pkg::DATA_W-1:0] a_rdata;
  logic [tmm_pkg::DATA_W-1:0] b_rdata;
  logic [tmm_pkg::DATA_W-1:0] op_a;
  logic [tmm_pkg::DATA_W-1:0] op_b;
  logic [tmm_pkg::DATA_W-1:0] acc;

  assign cfg_ready = 1'b1;

  assign cmd_take   = cmd_valid && !cmd_stall;
  assign is_query   = cmd_take && (cmd == tmm_pkg::CMD_QUERY);
  assign load_ok    = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
  assign a_we       = cmd_take && (cmd == tmm_pkg::CMD_LOAD_A) && load_ok;
  assign b_we       = cmd_take && (cmd == tmm_pkg::CMD_LOAD_B) && load_ok;
  assign res_free   = !res_valid || !res_stall;
  assign pipe_empty = !rd_vld && !prod_vld;
  assign finish     = (state == tmm_pkg::ST_DRAIN) && pipe_empty && res_free;

  // clamp the configured size to the store side
  assign n_eff = (CNT_W'(dim_q) > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(dim_q);

  assign waddr   = ADDR_W'(int'(row) * MAX_DIM + int'(col));
  assign a_raddr = ADDR_W'(int'(k) * MAX_DIM + int'(qi));
  assign b_raddr = ADDR_W'(int'(k) * MAX_DIM + int'(qj));

  // drop operands whose index lies outside the store
  assign op_a = a_ok ? a_rdata : '0;
  assign op_b = b_ok ? b_rdata : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      tmm_pkg::ST_IDLE: begin
        if (is_query) begin
          state_next = (n_eff == '0) ? tmm_pkg::ST_DRAIN : tmm_pkg::ST_RUN;
        end
      end
      tmm_pkg::ST_RUN: begin
        if (k == n_q - CNT_W'(1)) begin
          state_next = tmm_pkg::ST_DRAIN;
        end
      end
      tmm_pkg::ST_DRAIN: begin
        if (pipe_empty && res_free) begin
          state_next = tmm_pkg::ST_IDLE;
        end
      end
      default: state_next = tmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall      = (state != tmm_pkg::ST_IDLE);
    issue          = (state == tmm_pkg::ST_RUN);
    mac_ctrl.clear = is_query;
    mac_ctrl.en    = rd_vld;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tmm_pkg::ST_IDLE;
      dim_q     <= 7'd64;
      rd_vld    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (cfg_valid && cfg_ready) begin
        dim_q <= dim;
      end
      if (finish) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_query) begin
      k    <= '0;
      n_q  <= n_eff;
      qi   <= row;
      qj   <= col;
      a_ok <= (int'(row) < MAX_DIM);
      b_ok <= (int'(col) < MAX_DIM);
    end else if (issue) begin
      k <= k + CNT_W'(1);
    end
    if (finish) begin
      product <= signed'(acc);
      out_row <= qi;
      out_col <= qj;
    end
  end

  tmm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  tmm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  tmm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mac_ctrl),
    .a        (op_a),
    .b        (op_b),
    .acc      (acc),
    .prod_vld (prod_vld)
  );

  `ASSERT_NEVER(a_idle_no_read, (state == tmm_pkg::ST_IDLE) && rd_vld, "read in flight while idle")
  `ASSERT_HOLDS(a_query_busy, is_query |=> (state != tmm_pkg::ST_IDLE), "query did not start")
  `ASSERT_HOLDS(a_res_from_drain, $rose(res_valid) |-> $past(state == tmm_pkg::ST_DRAIN), "result without drain")
  `ASSERT_HOLDS(a_k_in_range, (state == tmm_pkg::ST_RUN) |-> (k < n_q), "k past size")

endmodule

>>> dv/transposed_matrix_multiply_core_tb.sv
// Testbench for the transposed matrix multiply core: drives loads, queries and sizes, checks products.
`timescale 1ns / 100ps

module transposed_matrix_multiply_core_tb;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         SIDE          = 64;
  localparam int         IDLE_LIMIT    = 5000;
  localparam int         SETTLE_CYCLES = 80;
  localparam int         ITEM_TARGET   = 1750;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [31:0] product;
    logic [5:0]  row;
    logic [5:0]  col;
  } product_entry_t;

  class tmm_scoreboard;
    logic [31:0]    a_mem [SIDE*SIDE];
    logic [31:0]    b_mem [SIDE*SIDE];
    logic [6:0]     side_len;
    product_entry_t pending_products [$];
    int             errors;
    int             checked;
    int             loads;
    int             queries;
    int             dropped;

    function new();
      side_len = 7'd64;
      errors   = 0;
      checked  = 0;
      loads    = 0;
      queries  = 0;
      dropped  = 0;
    endfunction

    function void set_side(logic [6:0] v);
      side_len = v;
    endfunction

    // Sum of At[k][i] * B[k][j] over the active size, wrapping at 32 bits.
    function logic [31:0] dot_product(logic [5:0] i, logic [5:0] j);
      int          n;
      int          k;
      logic [31:0] acc;
      n = (side_len > SIDE) ? SIDE : int'(side_len);
      acc = '0;
      for (k = 0; k < n; k++)
        acc = acc + a_mem[k*SIDE + int'(i)] * b_mem[k*SIDE + int'(j)];
      return acc;
    endfunction

    function void note_transfer(logic [1:0] c, logic [5:0] r, logic [5:0] cl,
                                logic [31:0] v);
      product_entry_t e;
      case (c)
        tmm_pkg::CMD_LOAD_A: begin
          a_mem[int'(r)*SIDE + int'(cl)] = v;
          loads++;
        end
        tmm_pkg::CMD_LOAD_B: begin
          b_mem[int'(r)*SIDE + int'(cl)] = v;
          loads++;
        end
        tmm_pkg::CMD_QUERY: begin
          e.product = dot_product(r, cl);
          e.row     = r;
          e.col     = cl;
          pending_products.push_back(e);
          queries++;
        end
        default: dropped++;
      endcase
    endfunction

    function void check_product(logic [31:0] p, logic [5:0] r, logic [5:0] c);
      product_entry_t e;
      if (pending_products.size() == 0) begin
        $display("%0t: product %h at (%0d,%0d) with no query waiting", $time, p, r, c);
        errors++;
        return;
      end
      e = pending_products.pop_front();
      if (p !== e.product) begin
        $display("%0t: product expected %h actual %h", $time, e.product, p);
        errors++;
      end
      if (r !== e.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, e.row, r);
        errors++;
      end
      if (c !== e.col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, e.col, c);
        errors++;
      end
      checked++;
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  logic [1:0]         cmd       = tmm_pkg::CMD_LOAD_A;
  logic [5:0]         row       = '0;
  logic [5:0]         col       = '0;
  logic signed [31:0] value     = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic signed [31:0] product;
  logic [5:0]         out_row;
  logic [5:0]         out_col;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [6:0]         cfg_dim   = '0;

  tmm_scoreboard sb;
  int            send_idle_pct = 0;
  int            stall_pct     = 0;
  int            issued        = 0;
  int            side_now      = SIDE;
  int            quiet_cycles  = 0;
  bit            a_loaded [SIDE][SIDE];
  bit            b_loaded [SIDE][SIDE];

  transposed_matrix_multiply_core #(
    .MAX_DIM(SIDE)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .row      (row),
    .col      (col),
    .value    (value),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .product  (product),
    .out_row  (out_row),
    .out_col  (out_col),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .dim      (cfg_dim)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    res_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Check results before noting new transfers; watch for a hung block.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) sb.check_product(product, out_row, out_col);
      if (cmd_valid && !cmd_stall) sb.note_transfer(cmd, row, col, value);
      if (cfg_valid && cfg_ready) sb.set_side(cfg_dim);
      if ((res_valid && !res_stall) || (cmd_valid && !cmd_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return 32'($signed($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] c, input logic [5:0] r, input logic [5:0] cl,
                           input logic [31:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    row       <= r;
    col       <= cl;
    value     <= v;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (c == tmm_pkg::CMD_LOAD_A) a_loaded[r][cl] = 1'b1;
    if (c == tmm_pkg::CMD_LOAD_B) b_loaded[r][cl] = 1'b1;
    if (c != CMD_UNUSED) issued++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (sb.pending_products.size() != 0) @(posedge clk);
  endtask

  // Hold until the core is idle, then transfer the new size.
  task automatic write_side(input logic [6:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_dim   <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    side_now = (v > SIDE) ? SIDE : int'(v);
  endtask

  // Fill any operand elements the query will read, then issue it.
  task automatic run_query(input logic [5:0] i, input logic [5:0] j, input bit refresh);
    int k;
    for (k = 0; k < side_now; k++) begin
      if (refresh || !a_loaded[k][i]) send_item(tmm_pkg::CMD_LOAD_A, 6'(k), i, pick_value());
      if (refresh || !b_loaded[k][j]) send_item(tmm_pkg::CMD_LOAD_B, 6'(k), j, pick_value());
    end
    send_item(tmm_pkg::CMD_QUERY, i, j, $urandom);
  endtask

  task automatic run_random(input int count);
    int         stop;
    int         r;
    logic [5:0] i;
    logic [5:0] j;
    stop = issued + count;
    while (issued < stop) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_item($urandom_range(0, 1) ? tmm_pkg::CMD_LOAD_B : tmm_pkg::CMD_LOAD_A,
                  6'($urandom), 6'($urandom), pick_value());
      end else if (r < 8) begin
        send_item(CMD_UNUSED, 6'($urandom), 6'($urandom), $urandom);
      end else begin
        // Keep large sizes on a few columns so the fill cost stays low.
        if (side_now > 16) begin
          i = 6'($urandom_range(0, 3));
          j = 6'($urandom_range(0, 3));
        end else begin
          i = 6'($urandom_range(0, SIDE - 1));
          j = 6'($urandom_range(0, SIDE - 1));
        end
        if (r < 10) wait_drained();
        run_query(i, j, (side_now <= 16) && ($urandom_range(0, 2) == 0));
      end
    end
  endtask

  task automatic run_phase(input logic [6:0] d, input idle_mode_t mode, input int count);
    write_side(d);
    send_idle_pct = (mode == IDLE_SENDER) ? 52 : (mode == IDLE_BOTH) ? 34 : 0;
    stall_pct     = (mode == IDLE_RECEIVER) ? 52 : (mode == IDLE_BOTH) ? 34 : 0;
    run_random(count);
  endtask

  task automatic run_directed();
    write_side(7'd2);
    // Extreme operands whose products wrap to the sign bit and cancel.
    send_item(tmm_pkg::CMD_LOAD_A, 6'd0, 6'd0, 32'h7fff_ffff);
    send_item(tmm_pkg::CMD_LOAD_A, 6'd1, 6'd0, 32'h8000_0000);
    send_item(tmm_pkg::CMD_LOAD_B, 6'd0, 6'd63, 32'h8000_0000);
    send_item(tmm_pkg::CMD_LOAD_B, 6'd1, 6'd63, 32'hffff_ffff);
    send_item(tmm_pkg::CMD_QUERY, 6'd0, 6'd63, 32'h0000_0000);
    send_item(tmm_pkg::CMD_LOAD_A, 6'd0, 6'd63, 32'hffff_ffff);
    send_item(tmm_pkg::CMD_LOAD_A, 6'd1, 6'd63, 32'h0000_0000);
    send_item(tmm_pkg::CMD_LOAD_B, 6'd0, 6'd0, 32'hffff_ffff);
    send_item(tmm_pkg::CMD_LOAD_B, 6'd1, 6'd0, 32'h7fff_ffff);
    send_item(tmm_pkg::CMD_QUERY, 6'd63, 6'd0, 32'hffff_ffff);
    send_item(tmm_pkg::CMD_QUERY, 6'd63, 6'd63, 32'h8000_0000);
    send_item(CMD_UNUSED, 6'd63, 6'd63, 32'hffff_ffff);
    send_item(tmm_pkg::CMD_QUERY, 6'd0, 6'd0, 32'h7fff_ffff);
    write_side(7'd1);
    send_item(tmm_pkg::CMD_QUERY, 6'd0, 6'd63, 32'h0000_0000);
    // Empty sum: nothing is read, so any indices are fine.
    write_side(7'd0);
    send_item(tmm_pkg::CMD_QUERY, 6'd42, 6'd21, 32'h0000_0000);
  endtask

  initial begin
    int p;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_phase(7'd5, IDLE_NONE, 200);
    run_phase(7'd1, IDLE_SENDER, 120);
    run_phase(7'd64, IDLE_RECEIVER, 260);
    run_phase(7'd127, IDLE_BOTH, 120);
    run_phase(7'd0, IDLE_NONE, 40);
    run_phase(7'd65, IDLE_SENDER, 60);
    run_phase(7'd8, IDLE_BOTH, 200);
    p = 0;
    while (issued < ITEM_TARGET) begin
      run_phase(7'($urandom_range(1, 12)), idle_mode_t'(p % 4), 150);
      p++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d products from %0d queries after %0d loads; %0d unused commands dropped",
             sb.checked, sb.queries, sb.loads, sb.dropped);
    $display("Sizes 0, 1, 2, 64, 65, 127 and random small sizes under four idle patterns");
    if (sb.errors == 0 && sb.pending_products.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
